// ===== src/rtt_pkg.sv =====
// Package for the resistance-to-temperature core: fixed-point step factors,
// status codes, register indexes and defaults. Used by resistance_to_temperature_core.
// No dependencies.
package rtt_pkg;

    // Default limit on the number of 0.48 percent steps in one search.
    localparam int MAX_STEPS_DEF = 255;

    // Width of the shared multiplier operands.
    localparam int MUL_W = 32;

    // Width of the running power; holds 1.0048**1023 with 24 fraction bits.
    localparam int PW_W = 32;

    localparam int FRAC_W = 24;

    localparam logic [PW_W-1:0]  FX_ONE  = 32'd16777216;
    localparam logic [63:0]      FX_HALF = 64'd8388608;
    localparam logic [MUL_W-1:0] FX_UP   = 32'd16857747;
    localparam logic [MUL_W-1:0] FX_DOWN = 32'd16696685;

    localparam logic [7:0]       BASE_TEMP   = 8'd50;
    localparam logic [MUL_W-1:0] REF_OHMS    = 32'd510;
    localparam logic [15:0]      MIN_SENSE   = 16'd50;
    localparam logic [MUL_W-1:0] MIN_PER_LEN = 32'd73;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_WIRE_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OHMS_AT_50C = 8'd1;

    localparam logic [15:0] WIRE_LENGTH_RST = 16'd1;
    localparam logic [15:0] OHMS_AT_50C_RST = 16'd100;

    typedef enum logic [1:0] {
        STATUS_VALID = 2'd0,
        STATUS_BAD   = 2'd1,
        STATUS_LOW   = 2'd2
    } t_status;

endpackage

// ===== src/resistance_to_temperature_core.sv =====
// Resistance-to-temperature core: converts two millivolt readings into a
// saturated temperature code with one shared 32x32 multiplier and a sequencer.
// Depends on rtt_pkg.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+------------------------------------
//  input    | start, busy (taken: start&!busy) | i_sense_millivolts, i_total_millivolts
//  result   | o_result_valid (one-cycle strobe)| o_temperature, o_status
//  config   | i_cfg_valid, o_cfg_ready         | i_cfg_index, i_cfg_data
//
// A bad reading gives its result in the cycle after the item is taken. Otherwise
// four setup multiplies run, a low-resistance result follows them, and a search
// of at most MAX_STEPS steps runs on the shared multiplier; each step rounds the
// power, forms the two partial products of the divider term and compares, which
// also forms the next power update. Reset is synchronous and restores the register
// defaults. busy is high while an item is in work; results cannot be stalled.
module resistance_to_temperature_core #(
    parameter int MAX_STEPS = rtt_pkg::MAX_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [15:0]                    i_sense_millivolts,
    input  logic [15:0]                    i_total_millivolts,
    output logic                           o_result_valid,
    output logic [7:0]                     o_temperature,
    output logic [1:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rtt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int TW     = ((STEP_W > 8) ? STEP_W : 8) + 1;
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_STEPS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_NUM   = 10'b00_0000_0010,
        S_WS    = 10'b00_0000_0100,
        S_LOW   = 10'b00_0000_1000,
        S_DEN   = 10'b00_0001_0000,
        S_PMUL  = 10'b00_0010_0000,
        S_ROUND = 10'b00_0100_0000,
        S_LO    = 10'b00_1000_0000,
        S_HI    = 10'b01_0000_0000,
        S_CMP   = 10'b10_0000_0000
    } t_state;

    t_state r_state;

    logic [15:0] r_wire_length;
    logic [15:0] r_ohms_at_50c;

    logic [15:0]             r_sense;
    logic [15:0]             r_diff;
    logic [24:0]             r_num;
    logic [31:0]             r_ws;
    logic [38:0]             r_low;
    logic [47:0]             r_den;
    logic                    r_up;
    logic [rtt_pkg::PW_W-1:0] r_pw;
    logic [63:0]             r_prod;
    logic [63:0]             r_acc;
    logic [STEP_W-1:0]       r_steps;

    logic       r_valid;
    logic [7:0] r_temp;
    logic [1:0] r_status;

    // Shared multiplier.
    logic [rtt_pkg::MUL_W-1:0] mul_a;
    logic [rtt_pkg::MUL_W-1:0] mul_b;
    logic [63:0]               mul_p;

    logic        up_now;
    logic        up_sel;
    logic        bad_reading;
    logic [63:0] round_sum;
    logic [63:0] den_pw;
    logic [63:0] num_scaled;
    logic        hit;
    logic        last_step;
    logic [TW-1:0] up_sum;
    logic [TW-1:0] down_diff;
    logic [7:0]  temp_code;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_result_valid = r_valid;
    assign o_temperature  = r_temp;
    assign o_status       = r_status;

    assign bad_reading = (i_sense_millivolts < rtt_pkg::MIN_SENSE) ||
                         (i_sense_millivolts > i_total_millivolts);

    assign up_now = ({23'd0, r_num} > r_den);
    assign up_sel = (r_state == S_PMUL) ? up_now : r_up;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_NUM: begin
                mul_a = {16'd0, r_diff};
                mul_b = rtt_pkg::REF_OHMS;
            end
            S_WS: begin
                mul_a = {16'd0, r_wire_length};
                mul_b = {16'd0, r_sense};
            end
            S_LOW: begin
                mul_a = r_ws;
                mul_b = rtt_pkg::MIN_PER_LEN;
            end
            S_DEN: begin
                mul_a = r_ws;
                mul_b = {16'd0, r_ohms_at_50c};
            end
            S_PMUL, S_CMP: begin
                mul_a = r_pw;
                mul_b = up_sel ? rtt_pkg::FX_UP : rtt_pkg::FX_DOWN;
            end
            S_LO: begin
                mul_a = {8'd0, r_den[23:0]};
                mul_b = r_pw;
            end
            S_HI: begin
                mul_a = {8'd0, r_den[47:24]};
                mul_b = r_pw;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign round_sum = r_prod + rtt_pkg::FX_HALF;

    // The divider term wraps at 64 bits, as the comparison is defined.
    assign den_pw     = r_acc + {r_prod[39:0], 24'd0};
    assign num_scaled = {15'd0, r_num, 24'd0};
    assign hit        = r_up ? (num_scaled <= den_pw) : (num_scaled >= den_pw);
    assign last_step  = hit || (r_steps == STEP_LIMIT);

    assign up_sum    = TW'(rtt_pkg::BASE_TEMP) + TW'(r_steps);
    assign down_diff = TW'(rtt_pkg::BASE_TEMP) - TW'(r_steps);

    always_comb begin
        if (r_up) begin
            temp_code = (up_sum > TW'(255)) ? 8'hFF : up_sum[7:0];
        end else begin
            temp_code = (TW'(r_steps) >= TW'(rtt_pkg::BASE_TEMP)) ? 8'd0 : down_diff[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wire_length <= rtt_pkg::WIRE_LENGTH_RST;
            r_ohms_at_50c <= rtt_pkg::OHMS_AT_50C_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == rtt_pkg::REG_WIRE_LENGTH) begin
                r_wire_length <= i_cfg_data;
            end else if (i_cfg_index == rtt_pkg::REG_OHMS_AT_50C) begin
                r_ohms_at_50c <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_valid <= start && bad_reading;
                    if (start) begin
                        if (bad_reading) begin
                            r_temp   <= 8'd0;
                            r_status <= rtt_pkg::STATUS_BAD;
                        end else begin
                            r_state <= S_NUM;
                        end
                        r_sense <= i_sense_millivolts;
                        r_diff  <= i_total_millivolts - i_sense_millivolts;
                    end
                end
                S_NUM: begin
                    r_valid <= 1'b0;
                    r_num   <= mul_p[24:0];
                    r_state <= S_WS;
                end
                S_WS: begin
                    r_valid <= 1'b0;
                    r_ws    <= mul_p[31:0];
                    r_state <= S_LOW;
                end
                S_LOW: begin
                    r_valid <= 1'b0;
                    r_low   <= mul_p[38:0];
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den <= mul_p[47:0];
                    if ({14'd0, r_num} < r_low) begin
                        r_valid  <= 1'b1;
                        r_temp   <= 8'd0;
                        r_status <= rtt_pkg::STATUS_LOW;
                        r_state  <= S_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_pw    <= rtt_pkg::FX_ONE;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    r_valid <= 1'b0;
                    r_up    <= up_now;
                    r_prod  <= mul_p;
                    r_steps <= STEP_W'(1);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_valid <= 1'b0;
                    r_pw    <= round_sum[55:24];
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_valid <= 1'b0;
                    r_acc   <= mul_p;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_valid <= 1'b0;
                    r_prod  <= mul_p;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // The next power product is formed here and dropped if the search ends.
                    if (last_step) begin
                        r_valid  <= 1'b1;
                        r_temp   <= temp_code;
                        r_status <= rtt_pkg::STATUS_VALID;
                        r_state  <= S_IDLE;
                    end else begin
                        r_valid <= 1'b0;
                        r_prod  <= mul_p;
                        r_steps <= r_steps + STEP_W'(1);
                        r_state <= S_ROUND;
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
